[rtl/rwrol_pkg.sv]
// Shared widths, defaults and command codes for the write record ring.
package rwrol_pkg;

  localparam int HANDLE_W        = 32;
  localparam int REC_LEN_W       = 16;
  localparam int OFFSET_W        = 20;
  localparam int SLOT_OUT_W      = 4;
  localparam int BYTE_W          = 16;

  localparam int RING_DEPTH_DEF  = 16;
  localparam int LENGTH_BITS_DEF = 16;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_FIND = 1'b1
  } cmd_t;

endpackage

[rtl/rwrol_if.sv]
// Request and response channel interfaces of the write record ring.
interface rwrol_in_if;
  logic                          valid;
  logic                          ready;
  rwrol_pkg::cmd_t               cmd;
  logic [rwrol_pkg::REC_LEN_W-1:0] record_length;
  logic [rwrol_pkg::HANDLE_W-1:0]  record_handle;
  logic [rwrol_pkg::OFFSET_W-1:0]  char_pos;

  modport source (output valid, cmd, record_length, record_handle, char_pos,
                  input ready);
  modport sink   (input valid, cmd, record_length, record_handle, char_pos,
                  output ready);
endinterface

interface rwrol_out_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [rwrol_pkg::SLOT_OUT_W-1:0] found_slot;
  logic [rwrol_pkg::HANDLE_W-1:0]   found_handle;
  logic [rwrol_pkg::BYTE_W-1:0]     byte_in_record;
  logic                             evicted;
  logic [rwrol_pkg::HANDLE_W-1:0]   evicted_handle;

  modport source (output valid, found, found_slot, found_handle, byte_in_record,
                  evicted, evicted_handle,
                  input ready);
  modport sink   (input valid, found, found_slot, found_handle, byte_in_record,
                  evicted, evicted_handle,
                  output ready);
endinterface

[rtl/rwrol_ram.sv]
// Simple dual port record memory: one write and one registered read per cycle.
module rwrol_ram #(
  parameter int DEPTH  = rwrol_pkg::RING_DEPTH_DEF,
  parameter int DATA_W = rwrol_pkg::LENGTH_BITS_DEF + rwrol_pkg::HANDLE_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/rwrol_ctrl.sv]
// Sequencer: ring pointers, add with eviction, find walk and result register.
module rwrol_ctrl #(
  parameter int RING_DEPTH  = rwrol_pkg::RING_DEPTH_DEF,
  parameter int LENGTH_BITS = rwrol_pkg::LENGTH_BITS_DEF,
  localparam int SLOT_W     = $clog2(RING_DEPTH),
  localparam int DATA_W     = LENGTH_BITS + rwrol_pkg::HANDLE_W
) (
  input  logic              clk,
  input  logic              rst,
  rwrol_in_if.sink          req,
  rwrol_out_if.source       rsp,
  output logic              mem_wr_en,
  output logic [SLOT_W-1:0] mem_wr_addr,
  output logic [DATA_W-1:0] mem_wr_data,
  output logic              mem_rd_en,
  output logic [SLOT_W-1:0] mem_rd_addr,
  input  logic [DATA_W-1:0] mem_rd_data
);

  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int OFF_W = rwrol_pkg::OFFSET_W;
  localparam int HND_W = rwrol_pkg::HANDLE_W;
  localparam int CMP_W = ((LENGTH_BITS > OFF_W) ? LENGTH_BITS : OFF_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_WALK,
    S_RESULT
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] read_slot;
  logic              ring_full;

  logic [SLOT_W-1:0] rd_idx;
  logic [SLOT_W-1:0] cur_slot;
  logic [CNT_W-1:0]  remain;
  logic [OFF_W-1:0]  sum;
  logic [OFF_W-1:0]  target;
  logic [LENGTH_BITS-1:0] add_len;
  logic [HND_W-1:0]  add_handle;

  logic                              res_found;
  logic [rwrol_pkg::SLOT_OUT_W-1:0]  res_slot;
  logic [HND_W-1:0]                  res_handle;
  logic [rwrol_pkg::BYTE_W-1:0]      res_byte;
  logic                              res_ev;
  logic [HND_W-1:0]                  res_ev_handle;

  logic                              out_valid;
  logic                              out_found;
  logic [rwrol_pkg::SLOT_OUT_W-1:0]  out_slot;
  logic [HND_W-1:0]                  out_handle;
  logic [rwrol_pkg::BYTE_W-1:0]      out_byte;
  logic                              out_ev;
  logic [HND_W-1:0]                  out_ev_handle;

  logic                   accept;
  logic [CNT_W-1:0]       vcount;
  logic [LENGTH_BITS-1:0] rd_len;
  logic [HND_W-1:0]       rd_handle;
  logic [CMP_W-1:0]       sum_plus;
  logic                   match;
  logic [SLOT_W-1:0]      ws_next;
  logic                   out_free;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;

  always_comb begin
    if (ring_full) begin
      vcount = CNT_W'(RING_DEPTH);
    end else if (write_slot >= read_slot) begin
      vcount = CNT_W'(write_slot) - CNT_W'(read_slot);
    end else begin
      vcount = CNT_W'(RING_DEPTH) + CNT_W'(write_slot) - CNT_W'(read_slot);
    end
  end

  assign rd_len    = mem_rd_data[DATA_W-1 -: LENGTH_BITS];
  assign rd_handle = mem_rd_data[HND_W-1:0];
  assign sum_plus  = CMP_W'(sum) + CMP_W'(rd_len);
  assign match     = (sum_plus > CMP_W'(target));
  assign ws_next   = next_slot(write_slot);

  // memory port control
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = rd_idx;
    case (state)
      S_IDLE: begin
        mem_rd_addr = (req.cmd == rwrol_pkg::CMD_FIND) ? read_slot : write_slot;
        mem_rd_en   = req.valid &&
                      ((req.cmd == rwrol_pkg::CMD_ADD) || (vcount != '0));
      end
      S_WALK: begin
        mem_rd_en = (remain != '0) && !match;
      end
      default: begin
        mem_rd_en = 1'b0;
      end
    endcase
  end

  assign mem_wr_en   = (state == S_ADD);
  assign mem_wr_addr = write_slot;
  assign mem_wr_data = {add_len, add_handle};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      write_slot <= '0;
      read_slot  <= '0;
      ring_full  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if ((state == S_RESULT) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_found     <= 1'b0;
            res_slot      <= '0;
            res_handle    <= '0;
            res_byte      <= '0;
            res_ev        <= 1'b0;
            res_ev_handle <= '0;
            add_len       <= LENGTH_BITS'(req.record_length);
            add_handle    <= req.record_handle;
            target        <= req.char_pos;
            sum           <= '0;
            cur_slot      <= read_slot;
            rd_idx        <= next_slot(read_slot);
            remain        <= vcount - 1'b1;
            if (req.cmd == rwrol_pkg::CMD_ADD) begin
              state <= S_ADD;
            end else if (vcount == '0) begin
              state <= S_RESULT;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_ADD: begin
          // read data is the handle at the write slot
          res_ev        <= ring_full;
          res_ev_handle <= ring_full ? rd_handle : '0;
          if (ring_full) begin
            read_slot <= next_slot(read_slot);
          end
          write_slot <= ws_next;
          ring_full  <= ring_full || (ws_next == read_slot);
          state      <= S_RESULT;
        end
        S_WALK: begin
          if (match) begin
            res_found  <= 1'b1;
            res_slot   <= rwrol_pkg::SLOT_OUT_W'(cur_slot);
            res_handle <= rd_handle;
            res_byte   <= rwrol_pkg::BYTE_W'(target - sum);
            state      <= S_RESULT;
          end else begin
            // no match: sum + len stays at or below target
            sum <= OFF_W'(sum_plus);
            if (remain == '0) begin
              state <= S_RESULT;
            end else begin
              cur_slot <= rd_idx;
              rd_idx   <= next_slot(rd_idx);
              remain   <= remain - 1'b1;
            end
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESULT) && out_free) begin
      out_found     <= res_found;
      out_slot      <= res_slot;
      out_handle    <= res_handle;
      out_byte      <= res_byte;
      out_ev        <= res_ev;
      out_ev_handle <= res_ev_handle;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.found          = out_found;
  assign rsp.found_slot     = out_slot;
  assign rsp.found_handle   = out_handle;
  assign rsp.byte_in_record = out_byte;
  assign rsp.evicted        = out_ev;
  assign rsp.evicted_handle = out_ev_handle;

endmodule

[rtl/write_record_ring_with_offset_lookup_top.sv]
// Ring of write records with overwrite of the oldest record and offset lookup.
// Each request word either adds a record (length, handle) or finds the record
// holding a character offset across all stored records, oldest first; every
// request gives exactly one response word. Requests are taken one at a time.
// An add passes through accept, read of the slot to be overwritten plus
// write, and hand-off to the output register. A find passes through accept,
// a walk over the records up to and including the match (all stored records
// on a miss, up to RING_DEPTH), and hand-off; the walk reads the record
// memory, which has one read port, one record per cycle. The response
// register lets the next request be taken while a response still waits;
// that next request then holds in its hand-off cycle until the waiting word
// is taken.
// No clearing pass runs after reset; only records written since reach a
// response.
module write_record_ring_with_offset_lookup_top #(
  parameter int RING_DEPTH  = rwrol_pkg::RING_DEPTH_DEF,
  parameter int LENGTH_BITS = rwrol_pkg::LENGTH_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  rwrol_in_if.sink    req,
  rwrol_out_if.source rsp
);

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int DATA_W = LENGTH_BITS + rwrol_pkg::HANDLE_W;

  logic              mem_wr_en;
  logic [SLOT_W-1:0] mem_wr_addr;
  logic [DATA_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [SLOT_W-1:0] mem_rd_addr;
  logic [DATA_W-1:0] mem_rd_data;

  rwrol_ctrl #(
    .RING_DEPTH  (RING_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  rwrol_ram #(
    .DEPTH  (RING_DEPTH),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

[rtl/rwrol_checker.sv]
// Port-level checks of the write record ring, bound to the top level.
module rwrol_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic                             found,
  input logic [rwrol_pkg::SLOT_OUT_W-1:0] found_slot,
  input logic [rwrol_pkg::HANDLE_W-1:0]   found_handle,
  input logic [rwrol_pkg::BYTE_W-1:0]     byte_in_record,
  input logic                             evicted,
  input logic [rwrol_pkg::HANDLE_W-1:0]   evicted_handle
);

  // one request in flight: the block is busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(evicted)
      && $stable(found_handle) && $stable(evicted_handle))
    else $error("response word changed while stalled");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(found && evicted))
    else $error("response reports both a find hit and an eviction");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> (found_slot == '0) && (found_handle == '0)
      && (byte_in_record == '0))
    else $error("miss response carries nonzero find fields");

  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !evicted |-> (evicted_handle == '0))
    else $error("evicted handle set without eviction");

endmodule

bind write_record_ring_with_offset_lookup_top rwrol_checker u_rwrol_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .found          (rsp.found),
  .found_slot     (rsp.found_slot),
  .found_handle   (rsp.found_handle),
  .byte_in_record (rsp.byte_in_record),
  .evicted        (rsp.evicted),
  .evicted_handle (rsp.evicted_handle)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench: directed table and random traffic for the record ring.
module tb;

  localparam int DEPTH          = rwrol_pkg::RING_DEPTH_DEF;
  localparam int LEN_W          = rwrol_pkg::REC_LEN_W;
  localparam int HND_W          = rwrol_pkg::HANDLE_W;
  localparam int OFF_W          = rwrol_pkg::OFFSET_W;
  localparam int SLOT_W         = rwrol_pkg::SLOT_OUT_W;
  localparam int BYTE_W         = rwrol_pkg::BYTE_W;
  localparam int RAND_PER_PHASE = 285;
  localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;

  typedef struct packed {
    rwrol_pkg::cmd_t  cmd;
    logic [LEN_W-1:0] rec_len;
    logic [HND_W-1:0] rec_handle;
    logic [OFF_W-1:0] offset;
  } ring_word_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [HND_W-1:0]  handle;
    logic [BYTE_W-1:0] byte_off;
    logic              evicted;
    logic [HND_W-1:0]  ev_handle;
  } lookup_t;

  typedef struct {
    ring_word_t w;
    bit         typed;
    lookup_t    rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  rwrol_in_if  req ();
  rwrol_out_if rsp ();

  write_record_ring_with_offset_lookup_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the ring
  logic [LEN_W-1:0] shadow_len    [DEPTH];
  logic [HND_W-1:0] shadow_handle [DEPTH];
  int unsigned      shadow_wr;
  int unsigned      shadow_rd;
  bit               shadow_full;

  lookup_t     pending_lookups[$];
  int          errors;
  int          src_idle_pct;
  int          dst_stall_pct;
  int unsigned n_adds, n_finds, n_hits, n_evicts;

  function automatic int unsigned records_held();
    if (shadow_full) return DEPTH;
    return (shadow_wr + DEPTH - shadow_rd) % DEPTH;
  endfunction

  function automatic int unsigned bytes_before(int unsigned k);
    int unsigned total;
    total = 0;
    for (int unsigned i = 0; i < k; i++)
      total += shadow_len[(shadow_rd + i) % DEPTH];
    return total;
  endfunction

  // Applies one word to the shadow ring and returns the response it causes.
  function automatic lookup_t ring_apply(ring_word_t w);
    lookup_t     r;
    int unsigned run;
    int unsigned n;
    int unsigned idx;
    r = '0;
    if (w.cmd == rwrol_pkg::CMD_ADD) begin
      if (shadow_full) begin
        r.evicted   = 1'b1;
        r.ev_handle = shadow_handle[shadow_wr];
        shadow_rd   = (shadow_rd + 1) % DEPTH;
      end
      shadow_len[shadow_wr]    = w.rec_len;
      shadow_handle[shadow_wr] = w.rec_handle;
      shadow_wr = (shadow_wr + 1) % DEPTH;
      if (shadow_wr == shadow_rd) shadow_full = 1'b1;
    end else begin
      run = 0;
      n   = records_held();
      for (int unsigned i = 0; i < n; i++) begin
        idx = (shadow_rd + i) % DEPTH;
        if (!r.found) begin
          if (run + shadow_len[idx] > w.offset) begin
            r.found    = 1'b1;
            r.slot     = SLOT_W'(idx);
            r.handle   = shadow_handle[idx];
            r.byte_off = BYTE_W'(w.offset - run);
          end else begin
            run += shadow_len[idx];
          end
        end
      end
    end
    return r;
  endfunction

  function automatic ring_word_t rand_word();
    ring_word_t  w;
    int unsigned roll;
    int unsigned k;
    int unsigned off;
    w.rec_handle = $urandom;
    w.rec_len    = LEN_W'($urandom);
    w.offset     = OFF_W'($urandom);
    roll = $urandom_range(99);
    if ($urandom_range(99) < 50) begin
      w.cmd = rwrol_pkg::CMD_ADD;
      if (roll < 10)      w.rec_len = '0;
      else if (roll < 20) w.rec_len = '1;
      else if (roll >= 35) w.rec_len = LEN_W'($urandom_range(64, 1));
    end else begin
      w.cmd = rwrol_pkg::CMD_FIND;
      if (roll < 55) begin
        // includes the first offset past the end
        w.offset = OFF_W'($urandom_range(bytes_before(records_held()), 0));
      end else if (roll < 80) begin
        // record boundaries: start of a record or last byte of the one before
        k   = $urandom_range(records_held(), 0);
        off = bytes_before(k);
        if (off > 0 && $urandom_range(1) == 1) off--;
        w.offset = OFF_W'(off);
      end
    end
    return w;
  endfunction

  function automatic dir_row_t mk_row(rwrol_pkg::cmd_t c, logic [LEN_W-1:0] len,
                                      logic [HND_W-1:0] h, logic [OFF_W-1:0] off,
                                      bit typed, lookup_t r);
    dir_row_t row;
    row.w     = '{c, len, h, off};
    row.typed = typed;
    row.rsp   = r;
    return row;
  endfunction

  task automatic send_word(ring_word_t w, bit typed, lookup_t typed_rsp);
    lookup_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid         <= 1'b1;
    req.cmd           <= w.cmd;
    req.record_length <= w.rec_len;
    req.record_handle <= w.rec_handle;
    req.char_pos      <= w.offset;
    do @(posedge clk); while (req.ready !== 1'b1);
    pred = ring_apply(w);
    pending_lookups.push_back(typed ? typed_rsp : pred);
    if (w.cmd == rwrol_pkg::CMD_ADD) n_adds++;
    else n_finds++;
    @(negedge clk);
  endtask

  task automatic cmp_field(string name, longint unsigned exp_v, longint unsigned got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(negedge clk) rsp.ready <= ($urandom_range(99) >= dst_stall_pct);

  always @(posedge clk) begin : rsp_check
    lookup_t exp_r;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_lookups.size() == 0) begin
        $error("response word with nothing expected");
        errors++;
      end else begin
        exp_r = pending_lookups.pop_front();
        cmp_field("found",          exp_r.found,     rsp.found);
        cmp_field("found_slot",     exp_r.slot,      rsp.found_slot);
        cmp_field("found_handle",   exp_r.handle,    rsp.found_handle);
        cmp_field("byte_in_record", exp_r.byte_off,  rsp.byte_in_record);
        cmp_field("evicted",        exp_r.evicted,   rsp.evicted);
        cmp_field("evicted_handle", exp_r.ev_handle, rsp.evicted_handle);
        if (rsp.found === 1'b1) n_hits++;
        if (rsp.evicted === 1'b1) n_evicts++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout: responses still outstanding: %0d", pending_lookups.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stim
    dir_row_t rows[$];
    int       src_pct[4];
    int       dst_pct[4];
    src_pct = '{0, 51, 0, 10};
    dst_pct = '{0, 0, 51, 10};
    errors        = 0;
    n_adds        = 0;
    n_finds       = 0;
    n_hits        = 0;
    n_evicts      = 0;
    src_idle_pct  = 0;
    dst_stall_pct = 0;
    shadow_wr     = 0;
    shadow_rd     = 0;
    shadow_full   = 1'b0;
    foreach (shadow_len[i]) begin
      shadow_len[i]    = '0;
      shadow_handle[i] = '0;
    end
    rst               = 1'b1;
    req.valid         = 1'b0;
    req.cmd           = rwrol_pkg::CMD_ADD;
    req.record_length = '0;
    req.record_handle = '0;
    req.char_pos      = '0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty ring: nothing to find
    rows.push_back(mk_row(rwrol_pkg::CMD_FIND, '0, '0, '0, 1'b1, '0));
    rows.push_back(mk_row(rwrol_pkg::CMD_FIND, '1, '1, '1, 1'b1, '0));
    // adds to a ring with room report nothing
    rows.push_back(mk_row(rwrol_pkg::CMD_ADD, '1, '1, '0, 1'b1, '0));
    rows.push_back(mk_row(rwrol_pkg::CMD_ADD, '0, '0, '1, 1'b1, '0));
    rows.push_back(mk_row(rwrol_pkg::CMD_FIND, '0, '0, 20'h0_0000, 1'b1,
                          lookup_t'{1'b1, 4'd0, 32'hFFFF_FFFF, 16'h0000, 1'b0, 32'h0}));
    rows.push_back(mk_row(rwrol_pkg::CMD_FIND, '0, '0, 20'h0_FFFE, 1'b1,
                          lookup_t'{1'b1, 4'd0, 32'hFFFF_FFFF, 16'hFFFE, 1'b0, 32'h0}));
    // just past the data; the empty record is walked over
    rows.push_back(mk_row(rwrol_pkg::CMD_FIND, '0, '0, 20'h0_FFFF, 1'b1, '0));
    rows.push_back(mk_row(rwrol_pkg::CMD_ADD, 16'd1, 32'h0000_0001, '0, 1'b0, '0));
    rows.push_back(mk_row(rwrol_pkg::CMD_FIND, '0, '0, 20'h0_FFFF, 1'b0, '0));
    // fill to the wrap point with maximum lengths
    for (int i = 0; i < DEPTH - 3; i++)
      rows.push_back(mk_row(rwrol_pkg::CMD_ADD, '1, 32'hA5A5_0000 + i, '0, 1'b0, '0));
    rows.push_back(mk_row(rwrol_pkg::CMD_FIND, '0, '0, '1, 1'b0, '0));
    // full ring: the oldest record goes
    rows.push_back(mk_row(rwrol_pkg::CMD_ADD, '1, 32'h5A5A_5A5A, '0, 1'b1,
                          lookup_t'{1'b0, 4'd0, 32'h0, 16'h0, 1'b1, 32'hFFFF_FFFF}));
    rows.push_back(mk_row(rwrol_pkg::CMD_FIND, '0, '0, '0, 1'b0, '0));

    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].rsp);

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = src_pct[ph];
      dst_stall_pct = dst_pct[ph];
      repeat (RAND_PER_PHASE) send_word(rand_word(), 1'b0, '0);
    end
    req.valid <= 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d request words sent: %0d adds, %0d finds", n_adds + n_finds, n_adds, n_finds);
    $display("%0d finds hit a record, %0d adds evicted, four flow-control phases",
             n_hits, n_evicts);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
